/* hdl/rob_pkg.sv */
// ---------------------------------------------------------------------------
// Reorder buffer package
// Shared constants, command and status codes, and payload types.
// ---------------------------------------------------------------------------
package rob_pkg;

  localparam int RobDepth = 32;
  localparam int IdxW     = $clog2(RobDepth);
  localparam int OccW     = $clog2(RobDepth + 1);

  typedef enum logic [2:0] {
    CMD_ALLOC     = 3'd0,
    CMD_COMPLETE  = 3'd1,
    CMD_DISPATCH  = 3'd2,
    CMD_COMMIT    = 3'd3,
    CMD_FLUSH_ALL = 3'd4,
    CMD_FLUSH_AFT = 3'd5,
    CMD_STORE_QRY = 3'd6,
    CMD_OLDEST_EX = 3'd7
  } cmd_t;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_EMPTY     = 3'd2;
  localparam logic [2:0] ST_NOT_READY = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;

  localparam logic [1:0] PH_ALLOC = 2'd0;
  localparam logic [1:0] PH_DISP  = 2'd1;
  localparam logic [1:0] PH_DONE  = 2'd2;

  typedef struct packed {
    logic [2:0]  command;
    logic [4:0]  entry_index;
    logic [63:0] pc;
    logic [63:0] inst_id;
    logic        store_op;
    logic [63:0] result_value;
    logic        exception_flag;
    logic        is_jump;
    logic [63:0] jump_addr;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  out_index;
    logic [63:0] out_pc;
    logic [63:0] out_id;
    logic [63:0] out_result;
    logic        out_exception;
    logic        out_is_jump;
    logic [63:0] out_target;
    logic        more_pending;
    logic        store_incomplete;
    logic        store_in_buffer;
  } out_item_t;

endpackage

/* hdl/rob_if.sv */
// ---------------------------------------------------------------------------
// Reorder buffer channels
// Valid/ready channels for command and result transactions.
// ---------------------------------------------------------------------------
interface rob_in_if;
  logic             valid;
  logic             ready;
  rob_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rob_out_if;
  logic              valid;
  logic              ready;
  rob_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hdl/rob_ram.sv */
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module rob_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* hdl/reorder_buffer_unit.sv */
// ---------------------------------------------------------------------------
// Reorder buffer unit
// Circular in-order reorder buffer driven by one command per transaction.
// ---------------------------------------------------------------------------
// One command is worked at a time. Allocate, complete and flush-all go
// from the idle state through the read state to the output state, where the
// result stays until it is taken; commit also passes the walk state for the
// RAM read of the head entry. Dispatch, store query and oldest exception
// walk the entries from the head one per cycle through a single RAM read
// port; flush-after clears the younger valid bits one per cycle.
// Entry payload lives in RAM; valid bits and phase are flip-flops.
module reorder_buffer_unit (
  input logic     clk,
  input logic     rst_n,
  rob_in_if.sink  in_ch,
  rob_out_if.source out_ch
);
  localparam int IW = rob_pkg::IdxW;
  localparam int OW = rob_pkg::OccW;
  localparam int EntW = 64 + 64 + 1;   // pc, id, store
  localparam int ResW = 64 + 1 + 1 + 64;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_WALK = 5'b00100,
    S_FLSH = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  rob_pkg::in_item_t  req_r;
  rob_pkg::out_item_t res_r, res_nxt;

  logic [rob_pkg::RobDepth-1:0] valid_r, valid_nxt;
  logic [1:0] phase_r [rob_pkg::RobDepth];
  logic [IW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [OW-1:0] occ_r, occ_nxt;
  logic [OW-1:0] k_r, k_nxt;
  logic [IW-1:0] slot_r, slot_nxt;
  logic          pend_r, pend_nxt;   // RAM data for slot_r arrives next cycle

  // Phase writes
  logic          ph_we;
  logic [IW-1:0] ph_addr;
  logic [1:0]    ph_val;

  // RAM ports
  logic          ent_we, res_we;
  logic [IW-1:0] ent_wa, res_wa, raddr;
  logic [EntW-1:0] ent_wd, ent_rd;
  logic [ResW-1:0] res_wd, res_rd;

  rob_ram #(.Width(EntW), .Depth(rob_pkg::RobDepth)) u_ent (
    .clk, .we(ent_we), .waddr(ent_wa), .wdata(ent_wd), .raddr(raddr), .rdata(ent_rd));
  rob_ram #(.Width(ResW), .Depth(rob_pkg::RobDepth)) u_res (
    .clk, .we(res_we), .waddr(res_wa), .wdata(res_wd), .raddr(raddr), .rdata(res_rd));

  logic [63:0] rd_pc, rd_id, rd_result, rd_target;
  logic        rd_store, rd_fault, rd_jump;
  assign {rd_pc, rd_id, rd_store} = ent_rd;
  assign {rd_result, rd_fault, rd_jump, rd_target} = res_rd;

  logic in_acc, out_acc;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.data  = res_r;
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] s);
    logic [IW:0] t;
    t = {1'b0, s} + 1'b1;
    if (t == (IW+1)'(rob_pkg::RobDepth)) begin
      t = '0;
    end
    return t[IW-1:0];
  endfunction

  function automatic logic [IW-1:0] walk_slot(input logic [IW-1:0] h, input logic [OW-1:0] k);
    logic [IW+1:0] t;
    t = {2'b0, h} + (IW+2)'(k);
    if (t >= (IW+2)'(rob_pkg::RobDepth)) begin
      t = t - (IW+2)'(rob_pkg::RobDepth);
    end
    return t[IW-1:0];
  endfunction

  rob_pkg::cmd_t cmd;
  assign cmd = rob_pkg::cmd_t'(req_r.command);
  logic [IW-1:0] ridx;
  assign ridx = req_r.entry_index[IW-1:0];
  logic idx_ok;
  assign idx_ok = ({{(8-IW){1'b0}}, ridx} == 8'(req_r.entry_index)) || (IW >= 5);

  always_comb begin
    state_nxt = state_r;
    valid_nxt = valid_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    occ_nxt = occ_r;
    k_nxt = k_r;
    slot_nxt = slot_r;
    pend_nxt = 1'b0;
    res_nxt = res_r;
    ph_we = 1'b0; ph_addr = slot_r; ph_val = rob_pkg::PH_ALLOC;
    ent_we = 1'b0; ent_wa = tail_r;
    ent_wd = {req_r.pc, req_r.inst_id, req_r.store_op};
    res_we = 1'b0; res_wa = ridx;
    res_wd = {req_r.result_value, req_r.exception_flag, req_r.is_jump, req_r.jump_addr};
    raddr = slot_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        res_nxt = '0;
        state_nxt = S_OUT;
        case (cmd)
          rob_pkg::CMD_ALLOC: begin
            if (occ_r == OW'(rob_pkg::RobDepth)) begin
              res_nxt.status = rob_pkg::ST_FULL;
            end else begin
              ent_we = 1'b1;
              res_we = 1'b1; res_wa = tail_r; res_wd = '0;
              ph_we = 1'b1; ph_addr = tail_r; ph_val = rob_pkg::PH_ALLOC;
              valid_nxt[tail_r] = 1'b1;
              tail_nxt = wrap_inc(tail_r);
              occ_nxt = occ_r + 1'b1;
              res_nxt.out_index = 5'(tail_r);
              res_nxt.out_pc = req_r.pc;
              res_nxt.out_id = req_r.inst_id;
            end
          end
          rob_pkg::CMD_COMPLETE: begin
            if (!idx_ok || !valid_r[ridx]) begin
              res_nxt.status = rob_pkg::ST_NOT_FOUND;
            end else begin
              res_we = 1'b1;
              ph_we = 1'b1; ph_addr = ridx; ph_val = rob_pkg::PH_DONE;
              res_nxt.out_index = req_r.entry_index;
            end
          end
          rob_pkg::CMD_COMMIT: begin
            if (occ_r == '0) begin
              res_nxt.status = rob_pkg::ST_EMPTY;
            end else if (!valid_r[head_r] || phase_r[head_r] != rob_pkg::PH_DONE) begin
              res_nxt.status = rob_pkg::ST_NOT_READY;
              res_nxt.out_index = 5'(head_r);
            end else begin
              slot_nxt = head_r;
              raddr = head_r;
              pend_nxt = 1'b1;
              state_nxt = S_WALK;
            end
          end
          rob_pkg::CMD_FLUSH_ALL: begin
            valid_nxt = '0;
            head_nxt = '0; tail_nxt = '0; occ_nxt = '0;
          end
          rob_pkg::CMD_FLUSH_AFT: begin
            if (!idx_ok || !valid_r[ridx]) begin
              res_nxt.status = rob_pkg::ST_NOT_FOUND;
            end else begin
              res_nxt.out_index = req_r.entry_index;
              slot_nxt = wrap_inc(ridx);
              k_nxt = '0;
              state_nxt = S_FLSH;
            end
          end
          default: begin
            // dispatch, store query, oldest exception: walk from head
            if (cmd != rob_pkg::CMD_STORE_QRY) begin
              res_nxt.status = rob_pkg::ST_NOT_FOUND;
            end
            k_nxt = '0;
            slot_nxt = head_r;
            raddr = head_r;
            if (occ_r != '0) begin
              pend_nxt = 1'b1;
              state_nxt = S_WALK;
            end
          end
        endcase
      end
      S_WALK: begin
        // RAM output holds slot_r data when pend_r is set
        if (pend_r) begin
          if (cmd == rob_pkg::CMD_COMMIT) begin
            res_nxt.out_index = 5'(slot_r);
            res_nxt.out_pc = rd_pc;
            res_nxt.out_id = rd_id;
            res_nxt.out_result = rd_result;
            res_nxt.out_exception = rd_fault;
            res_nxt.out_is_jump = rd_jump;
            res_nxt.out_target = rd_target;
            res_nxt.more_pending = !rd_fault && (occ_r > OW'(1));
            valid_nxt[head_r] = 1'b0;
            head_nxt = wrap_inc(head_r);
            occ_nxt = occ_r - 1'b1;
            state_nxt = S_OUT;
          end else begin
            logic hit;
            logic done;
            hit = 1'b0;
            done = 1'b0;
            if (valid_r[slot_r]) begin
              case (cmd)
                rob_pkg::CMD_DISPATCH: begin
                  if (phase_r[slot_r] == rob_pkg::PH_ALLOC) begin
                    hit = 1'b1;
                    ph_we = 1'b1; ph_val = rob_pkg::PH_DISP;
                  end
                end
                rob_pkg::CMD_STORE_QRY: begin
                  if (rd_id >= req_r.inst_id) begin
                    done = 1'b1;
                  end else if (rd_store) begin
                    res_nxt.store_in_buffer = 1'b1;
                    if (phase_r[slot_r] != rob_pkg::PH_DONE) begin
                      res_nxt.store_incomplete = 1'b1;
                    end
                  end
                end
                default: begin
                  if (rd_fault) begin
                    hit = 1'b1;
                    res_nxt.out_exception = 1'b1;
                  end
                end
              endcase
            end
            if (hit) begin
              res_nxt.status = rob_pkg::ST_OK;
              res_nxt.out_index = 5'(slot_r);
              res_nxt.out_pc = rd_pc;
              res_nxt.out_id = rd_id;
              done = 1'b1;
            end
            if (done || (k_r + 1'b1 >= occ_r)) begin
              state_nxt = S_OUT;
            end else begin
              k_nxt = k_r + 1'b1;
              slot_nxt = walk_slot(head_r, k_r + 1'b1);
              raddr = slot_nxt;
              pend_nxt = 1'b1;
            end
          end
        end
        if (state_nxt == S_WALK && !pend_nxt) begin
          raddr = slot_r;
          pend_nxt = 1'b1;
        end
      end
      S_FLSH: begin
        if (slot_r == tail_r || k_r == OW'(rob_pkg::RobDepth)) begin
          tail_nxt = wrap_inc(ridx);
          state_nxt = S_OUT;
        end else begin
          if (valid_r[slot_r]) begin
            valid_nxt[slot_r] = 1'b0;
            if (occ_r != '0) begin
              occ_nxt = occ_r - 1'b1;
            end
          end
          slot_nxt = wrap_inc(slot_r);
          k_nxt = k_r + 1'b1;
        end
      end
      S_OUT: begin
        if (out_acc) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      head_r <= '0;
      tail_r <= '0;
      occ_r <= '0;
      k_r <= '0;
      pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      occ_r <= occ_nxt;
      k_r <= k_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r <= in_ch.data;
    end
    slot_r <= slot_nxt;
    res_r <= res_nxt;
    if (ph_we) begin
      phase_r[ph_addr] <= ph_val;
    end
  end

  // The occupancy never exceeds the depth.
  a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OW'(rob_pkg::RobDepth))
    else $error("occupancy above depth");

  // A result stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(res_r))
    else $error("result dropped");

  // The buffer never takes a command while a result is offered.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("ready while result pending");

  // An idle empty buffer has head equal to tail or no valid bits set.
  a_empty_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE && occ_r == '0 |-> head_r == tail_r || valid_r == '0)
    else $error("pointer mismatch on empty");

endmodule
